@@ design/frmtrr_pkg.sv @@
// Shared types, constants and tables for the fixed-range memory-type register programmer.
// No dependencies; used by the front, back, top level and testbench.
package frmtrr_pkg;

    localparam int ADDR_WIDTH = 32;
    localparam int NUM_FIXED  = 11;
    localparam int IDX_W      = 4;

    // Address reduction to ADDR_WIDTH bits; a no-op at 32 or more.
    localparam logic [31:0] ADDR_MASK =
        (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_WIDTH) - 64'd1);

    // Span start and log2 of the granule for each fixed register
    localparam logic [31:0] SPAN_START [NUM_FIXED] = '{
        32'h0_0000, 32'h8_0000, 32'hA_0000, 32'hC_0000, 32'hC_8000, 32'hD_0000,
        32'hD_8000, 32'hE_0000, 32'hE_8000, 32'hF_0000, 32'hF_8000
    };
    localparam logic [4:0] GRAN_SHIFT [NUM_FIXED] = '{
        5'd16, 5'd14, 5'd14, 5'd12, 5'd12, 5'd12,
        5'd12, 5'd12, 5'd12, 5'd12, 5'd12
    };

    // Depth of the command and result queues
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PROGRAM = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_READ    = 2'd2
    } t_cmd;

    // What the back end does with the register file
    typedef enum logic [1:0] {
        OP_ZERO  = 2'd0,   // report zero, no register touched
        OP_READ  = 2'd1,   // report register, no change
        OP_MERGE = 2'd2,   // replace masked type bytes, report new value
        OP_LOAD  = 2'd3    // replace whole register, report new value
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic              status;
        logic [31:0]       next_base;
        logic [31:0]       rem_len;
        logic [7:0]        byte_mask;
        logic [63:0]       payload;
    } t_work;

    typedef struct packed {
        logic              status;
        logic [31:0]       next_base;
        logic [31:0]       rem_len;
        logic [IDX_W-1:0]  reg_index;
        logic [63:0]       reg_value;
    } t_result;

endpackage

@@ design/fixed_range_mtrr_programmer.sv @@
// Fixed-range memory-type register programmer, top level.
// Depends on frmtrr_pkg, frmtrr_front and frmtrr_back.
//
// Holds the eleven fixed-range type registers of the first megabyte (reset to
// zero) and runs program, whole-register write and read commands, one result
// per command. Throughput is one command per cycle while the result queue has
// room: the back end does one read-modify-write of the register file each
// cycle. A pushed command is registered in the command queue, then its result
// in the result queue, to be popped when nothing is waiting ahead of it.
// Two-entry queues sit before and after the register file; full rises when
// the command queue holds two, which happens only while results are not popped.
module fixed_range_mtrr_programmer import frmtrr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_base,
    input  logic [31:0] i_length,
    input  logic [7:0]  i_cache_type,
    input  logic [3:0]  i_reg_select,
    input  logic [63:0] i_reg_data,
    output logic        empty,
    input  logic        pop,
    output logic        o_status,
    output logic [31:0] o_next_base,
    output logic [31:0] o_remaining_length,
    output logic [3:0]  o_reg_index,
    output logic [63:0] o_reg_value
);

    logic    work_valid;
    logic    work_pop;
    t_work   work;
    t_result result;

    frmtrr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd        (i_cmd),
        .i_base       (i_base),
        .i_length     (i_length),
        .i_cache_type (i_cache_type),
        .i_reg_select (i_reg_select),
        .i_reg_data   (i_reg_data),
        .o_work_valid (work_valid),
        .o_work       (work),
        .i_work_pop   (work_pop)
    );

    frmtrr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (work_valid),
        .i_work       (work),
        .o_work_pop   (work_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_result     (result)
    );

    assign o_status           = result.status;
    assign o_next_base        = result.next_base;
    assign o_remaining_length = result.rem_len;
    assign o_reg_index        = result.reg_index;
    assign o_reg_value        = result.reg_value;

endmodule

@@ design/frmtrr_front.sv @@
// Front end: decodes and classifies commands and holds them in a short queue.
// Depends on frmtrr_pkg.
module frmtrr_front import frmtrr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_base,
    input  logic [31:0] i_length,
    input  logic [7:0]  i_cache_type,
    input  logic [3:0]  i_reg_select,
    input  logic [63:0] i_reg_data,
    output logic        o_work_valid,
    output t_work       o_work,
    input  logic        i_work_pop
);

    logic              hit;
    logic [IDX_W-1:0]  ridx;
    logic [4:0]        gshift;
    logic [31:0]       base_m;
    logic [31:0]       off;
    logic              aligned;
    logic [2:0]        slot;
    logic [3:0]        avail;
    logic [31:0]       lenq;
    logic [3:0]        cnt;
    logic [31:0]       consumed;
    logic [31:0]       rem;
    logic [31:0]       adv;
    logic              partial;
    logic [7:0]        bmask;
    t_work             work;

    t_work              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr, n_wr;
    logic [QPTR_W-1:0]  r_rd, n_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_push;

    always_comb begin
        base_m = i_base & ADDR_MASK;
        hit    = 1'b0;
        ridx   = '0;
        for (int k = 0; k < NUM_FIXED; k++) begin
            if (!hit && base_m >= SPAN_START[k] &&
                {1'b0, base_m} < {1'b0, SPAN_START[k]} + (33'd8 << GRAN_SHIFT[k])) begin
                hit  = 1'b1;
                ridx = IDX_W'(k);
            end
        end

        gshift   = GRAN_SHIFT[ridx];
        off      = base_m - SPAN_START[ridx];
        aligned  = (off & ((32'd1 << gshift) - 32'd1)) == 32'd0;
        slot     = 3'(off >> gshift);
        avail    = 4'd8 - {1'b0, slot};
        lenq     = i_length >> gshift;
        cnt      = (lenq >= 32'(avail)) ? avail : lenq[3:0];
        consumed = 32'(cnt) << gshift;
        rem      = i_length - consumed;
        adv      = (base_m + consumed) & ADDR_MASK;
        // a piece smaller than a granule remains inside this register
        partial  = (cnt < avail) && (rem != 32'd0);
        for (int k = 0; k < 8; k++) begin
            bmask[k] = (4'(k) >= {1'b0, slot}) && (4'(k) < ({1'b0, slot} + cnt));
        end

        work.op        = OP_ZERO;
        work.idx       = '0;
        work.status    = 1'b1;
        work.next_base = base_m;
        work.rem_len   = i_length;
        work.byte_mask = bmask;
        work.payload   = {8{i_cache_type}};

        case (i_cmd)
            CMD_PROGRAM: begin
                if (hit) begin
                    work.idx = ridx;
                    work.op  = OP_READ;
                    if (aligned) begin
                        work.next_base = adv;
                        work.rem_len   = rem;
                        if (!partial) begin
                            work.op     = OP_MERGE;
                            work.status = 1'b0;
                        end
                    end
                end
            end
            CMD_WRITE, CMD_READ: begin
                work.idx = i_reg_select;
                if (i_reg_select < IDX_W'(NUM_FIXED)) begin
                    work.status  = 1'b0;
                    work.op      = (i_cmd == CMD_WRITE) ? OP_LOAD : OP_READ;
                    work.payload = i_reg_data;
                end
            end
            default: ;
        endcase
    end

    assign o_full       = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_work_valid = (r_cnt != '0);
    assign o_work       = r_q[r_rd];
    assign do_push      = i_push && !o_full;

    always_comb begin
        n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr] <= work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (i_work_pop) begin
                r_rd <= n_rd;
            end
            case ({do_push, i_work_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ design/frmtrr_back.sv @@
// Back end: register file read-modify-write and the result queue.
// Depends on frmtrr_pkg.
module frmtrr_back import frmtrr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_work_valid,
    input  t_work       i_work,
    output logic        o_work_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output t_result     o_result
);

    logic [63:0]        r_regs [NUM_FIXED];
    logic [63:0]        cur;
    logic [63:0]        emask;
    logic [63:0]        new_val;
    logic               do_write;
    t_result            res;

    t_result            r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr, n_wr;
    logic [QPTR_W-1:0]  r_rd, n_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic               res_full;
    logic               do_pop;

    assign res_full   = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_work_pop = i_work_valid && !res_full;
    assign o_empty    = (r_cnt == '0);
    assign o_result   = r_q[r_rd];
    assign do_pop     = i_pop && !o_empty;

    always_comb begin
        cur = r_regs[i_work.idx];
        for (int k = 0; k < 8; k++) begin
            emask[k*8 +: 8] = {8{i_work.byte_mask[k]}};
        end
        new_val  = cur;
        do_write = 1'b0;
        case (i_work.op)
            OP_MERGE: begin
                new_val  = (cur & ~emask) | (i_work.payload & emask);
                do_write = 1'b1;
            end
            OP_LOAD: begin
                new_val  = i_work.payload;
                do_write = 1'b1;
            end
            OP_READ: new_val = cur;
            default: new_val = 64'd0;
        endcase

        res.status    = i_work.status;
        res.next_base = i_work.next_base;
        res.rem_len   = i_work.rem_len;
        res.reg_index = i_work.idx;
        res.reg_value = new_val;

        n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_FIXED; k++) begin
                r_regs[k] <= 64'd0;
            end
        end else if (o_work_pop && do_write) begin
            r_regs[i_work.idx] <= new_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_work_pop) begin
            r_q[r_wr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (o_work_pop) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            case ({o_work_pop, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ design/frmtrr_checker.sv @@
// Port-level checks for fixed_range_mtrr_programmer, attached by bind.
// Depends on the top level's port list only.
module frmtrr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        o_status,
    input logic [31:0] o_next_base,
    input logic [31:0] o_remaining_length,
    input logic [3:0]  o_reg_index,
    input logic [63:0] o_reg_value
);

    // no result may survive reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> empty)
        else $error("result shown right after reset");

    // an accepted beat into an idle block shows a result after the command and result queues
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && empty) |=> ##1 !empty)
        else $error("accepted command produced no result");

    // a successful command always names a real register
    a_ok_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_status) |-> (o_reg_index <= 4'd10))
        else $error("success reported with register index out of range");

    // hold a waiting result until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_next_base) &&
            $stable(o_remaining_length) && $stable(o_reg_index) && $stable(o_reg_value)))
        else $error("waiting result changed before pop");

endmodule

bind fixed_range_mtrr_programmer frmtrr_checker u_frmtrr_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .push               (push),
    .full               (full),
    .empty              (empty),
    .pop                (pop),
    .o_status           (o_status),
    .o_next_base        (o_next_base),
    .o_remaining_length (o_remaining_length),
    .o_reg_index        (o_reg_index),
    .o_reg_value        (o_reg_value)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for fixed_range_mtrr_programmer: directed and random
// program, whole-register write and read beats against a shadow register file.
// Depends on frmtrr_pkg and the fixed_range_mtrr_programmer RTL.
`timescale 1ns / 1ps

module tb_top;
    import frmtrr_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned RANDOM_ITEMS = 350;   // per random phase, two phases

    // Span start and granule bytes of each fixed register
    localparam logic [31:0] FR_SPAN_LO [NUM_FIXED] = '{
        32'h0_0000, 32'h8_0000, 32'hA_0000, 32'hC_0000, 32'hC_8000, 32'hD_0000,
        32'hD_8000, 32'hE_0000, 32'hE_8000, 32'hF_0000, 32'hF_8000
    };
    localparam logic [31:0] FR_GRANULE [NUM_FIXED] = '{
        32'h1_0000, 32'h4000, 32'h4000, 32'h1000, 32'h1000, 32'h1000,
        32'h1000, 32'h1000, 32'h1000, 32'h1000, 32'h1000
    };

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] base;
        logic [31:0] length;
        logic [7:0]  cache_type;
        logic [3:0]  reg_select;
        logic [63:0] reg_data;
    } t_mtrr_cmd;

    typedef enum int {RX_FREE, RX_COIN, RX_SLOW, RX_HOLD} t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_cmd = '0;
    logic [31:0] i_base = '0;
    logic [31:0] i_length = '0;
    logic [7:0]  i_cache_type = '0;
    logic [3:0]  i_reg_select = '0;
    logic [63:0] i_reg_data = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_status;
    logic [31:0] o_next_base;
    logic [31:0] o_remaining_length;
    logic [3:0]  o_reg_index;
    logic [63:0] o_reg_value;

    t_mtrr_cmd   pending_cmds[$];
    t_result     expected_results[$];
    logic [63:0] shadow_regs [NUM_FIXED];
    t_mtrr_cmd   beat_cmd;
    int unsigned burst_left;
    int unsigned gap_left;
    t_rx_mode    rx_mode;
    int unsigned rx_left;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    fixed_range_mtrr_programmer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_cmd              (i_cmd),
        .i_base             (i_base),
        .i_length           (i_length),
        .i_cache_type       (i_cache_type),
        .i_reg_select       (i_reg_select),
        .i_reg_data         (i_reg_data),
        .empty              (empty),
        .pop                (pop),
        .o_status           (o_status),
        .o_next_base        (o_next_base),
        .o_remaining_length (o_remaining_length),
        .o_reg_index        (o_reg_index),
        .o_reg_value        (o_reg_value)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Compute the result of one accepted beat and update the shadow registers
    function automatic t_result predict_mtrr_result(t_mtrr_cmd c);
        t_result     res;
        logic [31:0] cur_base;
        logic [31:0] cur_len;
        logic [31:0] gran;
        logic [31:0] offset;
        logic [63:0] set_mask;
        logic [63:0] clr_mask;
        int          r;
        int          slot;
        cur_base = c.base & ADDR_MASK;
        cur_len  = c.length;
        set_mask = '0;
        clr_mask = '0;
        res = '{status: 1'b1, next_base: cur_base, rem_len: cur_len,
                reg_index: '0, reg_value: '0};
        case (c.cmd)
            CMD_PROGRAM: begin
                r = 0;
                while (r < NUM_FIXED && !(cur_base >= FR_SPAN_LO[r] &&
                       cur_base < FR_SPAN_LO[r] + 8 * FR_GRANULE[r]))
                    r++;
                if (r < NUM_FIXED) begin
                    gran   = FR_GRANULE[r];
                    offset = cur_base - FR_SPAN_LO[r];
                    res.reg_index = r[3:0];
                    res.reg_value = shadow_regs[r];
                    if ((offset & (gran - 1)) == 0) begin
                        slot = int'(offset / gran);
                        while (slot < 8 && cur_len >= gran) begin
                            set_mask |= {56'd0, c.cache_type} << (slot * 8);
                            clr_mask |= 64'hFF << (slot * 8);
                            cur_len  -= gran;
                            cur_base  = (cur_base + gran) & ADDR_MASK;
                            slot++;
                        end
                        res.next_base = cur_base;
                        res.rem_len   = cur_len;
                        // a partial granule inside the register leaves it untouched
                        if (!(slot < 8 && cur_len != 0)) begin
                            shadow_regs[r] = (shadow_regs[r] & ~clr_mask) | set_mask;
                            res.status    = 1'b0;
                            res.reg_value = shadow_regs[r];
                        end
                    end
                end
            end
            CMD_WRITE, CMD_READ: begin
                res.reg_index = c.reg_select;
                if (c.reg_select < NUM_FIXED) begin
                    if (c.cmd == CMD_WRITE)
                        shadow_regs[c.reg_select] = c.reg_data;
                    res.status    = 1'b0;
                    res.reg_value = shadow_regs[c.reg_select];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic queue_cmd(logic [1:0] cmd, logic [31:0] base, logic [31:0] length,
                             logic [7:0] ctype, logic [3:0] sel, logic [63:0] data);
        t_mtrr_cmd c;
        c = '{cmd: cmd, base: base, length: length, cache_type: ctype,
              reg_select: sel, reg_data: data};
        pending_cmds.push_back(c);
    endtask

    // Mostly aligned program beats inside the table, plus writes, reads and noise
    task automatic queue_random_cmd();
        int unsigned kind;
        int unsigned r;
        logic [31:0] gran;
        logic [31:0] base;
        logic [31:0] length;
        logic [63:0] data;
        kind   = $urandom_range(0, 99);
        r      = $urandom_range(0, NUM_FIXED - 1);
        gran   = FR_GRANULE[r];
        base   = FR_SPAN_LO[r] + $urandom_range(0, 7) * gran;
        length = $urandom_range(0, 9) * gran;
        data   = {$urandom, $urandom};
        if (kind < 55) begin
            if ($urandom_range(0, 4) == 0)
                length += $urandom_range(1, gran - 1);
            else if ($urandom_range(0, 19) == 0)
                length = $urandom;
            queue_cmd(CMD_PROGRAM, base, length, 8'($urandom), 4'($urandom), data);
        end else if (kind < 65) begin
            base += $urandom_range(1, gran - 1);
            queue_cmd(CMD_PROGRAM, base, length, 8'($urandom), 4'($urandom), data);
        end else if (kind < 75) begin
            queue_cmd(CMD_WRITE, $urandom, $urandom, 8'($urandom), 4'(r), data);
        end else if (kind < 85) begin
            queue_cmd(CMD_READ, $urandom, $urandom, 8'($urandom), 4'(r), data);
        end else if (kind < 90) begin
            queue_cmd(2'($urandom_range(CMD_WRITE, CMD_READ)), $urandom, $urandom,
                      8'($urandom), 4'($urandom), data);
        end else if (kind < 95) begin
            queue_cmd(CMD_PROGRAM, $urandom, $urandom, 8'($urandom), 4'($urandom), data);
        end else begin
            queue_cmd(($urandom_range(0, 1) == 0) ? CMD_UNUSED : 2'($urandom),
                      $urandom, $urandom, 8'($urandom), 4'($urandom), data);
        end
    endtask

    // Hold until every queued beat went out and every result came back
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || push || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push       <= 1'b0;
            burst_left  = $urandom_range(1, 16);
            gap_left    = 0;
        end else if (!push || !full) begin
            if (push)
                expected_results.push_back(predict_mtrr_result(beat_cmd));
            if (gap_left == 0 && pending_cmds.size() != 0) begin
                beat_cmd      = pending_cmds.pop_front();
                i_cmd        <= beat_cmd.cmd;
                i_base       <= beat_cmd.base;
                i_length     <= beat_cmd.length;
                i_cache_type <= beat_cmd.cache_type;
                i_reg_select <= beat_cmd.reg_select;
                i_reg_data   <= beat_cmd.reg_data;
                push         <= 1'b1;
                burst_left    = burst_left - 1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                push <= 1'b0;
                if (gap_left != 0)
                    gap_left = gap_left - 1;
            end
        end
    end

    // Receiver: check the popped beat, then pick the next pop on the stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop    <= 1'b0;
            rx_mode = RX_FREE;
            rx_left = 0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: no expectation waiting");
                    mismatch_count++;
                end else begin
                    t_result exp_res;
                    exp_res = expected_results.pop_front();
                    if (o_status !== exp_res.status) begin
                        $error("status: expected %0h actual %0h", exp_res.status, o_status);
                        mismatch_count++;
                    end
                    if (o_next_base !== exp_res.next_base) begin
                        $error("next_base: expected %0h actual %0h",
                               exp_res.next_base, o_next_base);
                        mismatch_count++;
                    end
                    if (o_remaining_length !== exp_res.rem_len) begin
                        $error("remaining_length: expected %0h actual %0h",
                               exp_res.rem_len, o_remaining_length);
                        mismatch_count++;
                    end
                    if (o_reg_index !== exp_res.reg_index) begin
                        $error("reg_index: expected %0h actual %0h",
                               exp_res.reg_index, o_reg_index);
                        mismatch_count++;
                    end
                    if (o_reg_value !== exp_res.reg_value) begin
                        $error("reg_value: expected %0h actual %0h",
                               exp_res.reg_value, o_reg_value);
                        mismatch_count++;
                    end
                end
            end
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(RX_FREE, RX_HOLD));
                rx_left = $urandom_range(20, 120);
            end else begin
                rx_left = rx_left - 1;
            end
            case (rx_mode)
                RX_FREE: pop <= 1'b1;
                RX_COIN: pop <= 1'($urandom_range(0, 1));
                RX_SLOW: pop <= ($urandom_range(0, 3) == 0);
                default: pop <= 1'b0;
            endcase
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_FIXED; i++)
            shadow_regs[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats
        queue_cmd(CMD_READ,    32'h0,       32'h0,       8'h00, 4'd0,  64'h0);
        queue_cmd(CMD_WRITE,   32'h0,       32'h0,       8'h00, 4'd0,  {64{1'b1}});
        queue_cmd(CMD_WRITE,   32'h1234,    32'h5678,    8'h00, 4'd10, 64'h0);
        queue_cmd(CMD_WRITE,   32'h0,       32'h0,       8'h00, 4'd5,  64'h0123_4567_89AB_CDEF);
        // whole register 0 with length to spare
        queue_cmd(CMD_PROGRAM, 32'h0,       32'hFFFF_FFFF, 8'hFF, 4'd0, 64'h0);
        queue_cmd(CMD_PROGRAM, 32'h8_0000,  32'h8000,    8'h06, 4'd0,  64'h0);
        queue_cmd(CMD_PROGRAM, 32'hA_4000,  32'h4000,    8'h00, 4'd0,  64'h0);
        // zero length on an aligned base
        queue_cmd(CMD_PROGRAM, 32'hC_0000,  32'h0,       8'h55, 4'd0,  64'h0);
        // misaligned bases
        queue_cmd(CMD_PROGRAM, 32'hC_0800,  32'h1000,    8'h01, 4'd0,  64'h0);
        queue_cmd(CMD_PROGRAM, 32'h0_8000,  32'h1_0000,  8'h01, 4'd0,  64'h0);
        // partial granule inside the register, then one past its end
        queue_cmd(CMD_PROGRAM, 32'hF_8000,  32'h1800,    8'h04, 4'd0,  64'h0);
        queue_cmd(CMD_PROGRAM, 32'hF_F000,  32'h1800,    8'h04, 4'd0,  64'h0);
        // no register holds the base
        queue_cmd(CMD_PROGRAM, 32'h10_0000, 32'h1000,    8'h01, 4'd0,  64'h0);
        queue_cmd(CMD_PROGRAM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF, {64{1'b1}});
        // select out of range
        queue_cmd(CMD_WRITE,   32'h0,       32'h0,       8'h00, 4'd11, {64{1'b1}});
        queue_cmd(CMD_READ,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF, 64'h0);
        queue_cmd(CMD_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF, {64{1'b1}});
        queue_cmd(CMD_READ,    32'h0,       32'h0,       8'h00, 4'd1,  64'h0);
        queue_cmd(CMD_READ,    32'h0,       32'h0,       8'h00, 4'd2,  64'h0);
        queue_cmd(CMD_READ,    32'h0,       32'h0,       8'h00, 4'd10, 64'h0);
        queue_cmd(CMD_PROGRAM, 32'hF_0000,  32'h8000,    8'h05, 4'd0,  64'h0);
        queue_cmd(CMD_WRITE,   32'h0,       32'h0,       8'h00, 4'd3,  {64{1'b1}});
        queue_cmd(CMD_PROGRAM, 32'hC_7000,  32'h1000,    8'h00, 4'd0,  64'h0);
        queue_cmd(CMD_READ,    32'h0,       32'h0,       8'h00, 4'd3,  64'h0);
        wait_idle();

        repeat (RANDOM_ITEMS) queue_random_cmd();
        wait_idle();
        repeat (RANDOM_ITEMS) queue_random_cmd();
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
